@@ hdl/status_led_panel_controller_defines.svh @@
// assertion macros for the status led panel controller
// included by the top level; no other dependencies
// define NO_ASSERTIONS to compile the checks away
`ifndef STATUS_LED_PANEL_CONTROLLER_DEFINES_SVH
`define STATUS_LED_PANEL_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SLPC_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slpc: same-cycle check failed");

// next-cycle implication
`define SLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slpc: next-cycle check failed");

`else

`define SLPC_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define SLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/slpc_pkg.sv @@
// shared types, constants and led tables for the status led panel controller
// no dependencies
package slpc_pkg;

    // duty and brightness widths
    localparam int DUTY_BITS = 12;
    localparam int BRIGHT_W  = 7;
    localparam int TICK_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // scaler widths: product, quotient and reciprocal product
    localparam int MUL_W     = DUTY_BITS + BRIGHT_W;
    localparam int QUO_W     = DUTY_BITS + 1;
    localparam int RCP_W     = MUL_W + 16;
    localparam int RCP_SHIFT = 22;
    localparam logic [15:0] RCP_MUL = 16'd41943;

    // duty constants
    localparam logic [DUTY_BITS-1:0] DUTY_FULL = {DUTY_BITS{1'b1}};
    localparam logic [DUTY_BITS-1:0] DUTY_HALF = {1'b1, {(DUTY_BITS-1){1'b0}}};

    // percentages
    localparam logic [BRIGHT_W-1:0] PCT_RED    = 7'd80;
    localparam logic [BRIGHT_W-1:0] PCT_YEL    = 7'd60;
    localparam logic [BRIGHT_W-1:0] PCT_SCALE  = 7'd100;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MIN = 7'd5;
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 7'd100;

    // reset values of the registers
    localparam logic [BRIGHT_W-1:0] BRIGHT_RST = 7'd100;
    localparam logic [TICK_W-1:0]   BLINK_RST  = 16'd500;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK      = 1'b1;

    // input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // led numbers
    localparam logic [1:0] LED_POWER    = 2'd0;
    localparam logic [1:0] LED_GNSS     = 2'd1;
    localparam logic [1:0] LED_STEER    = 2'd2;
    localparam logic [1:0] LED_INERTIAL = 2'd3;

    typedef enum logic [1:0] {
        COL_OFF = 2'd0,
        COL_RED = 2'd1,
        COL_YEL = 2'd2,
        COL_GRN = 2'd3
    } t_colour;

    typedef struct packed {
        t_colour colour;
        logic    blink;
    } t_led_entry;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // colour and blink mode of one led given the current state codes
    function automatic t_led_entry f_led_entry(
        input logic [1:0] led,
        input logic [1:0] pwr,
        input logic [2:0] gnss,
        input logic [1:0] steer,
        input logic [1:0] inr
    );
        t_led_entry e;
        e = '{colour: COL_OFF, blink: 1'b0};
        case (led)
            LED_POWER: begin
                case (pwr)
                    2'd0:    e = '{colour: COL_RED, blink: 1'b0};
                    2'd1:    e = '{colour: COL_YEL, blink: 1'b1};
                    2'd2:    e = '{colour: COL_GRN, blink: 1'b0};
                    default: e = '{colour: COL_OFF, blink: 1'b0};
                endcase
            end
            LED_GNSS: begin
                case (gnss)
                    3'd1:    e = '{colour: COL_RED, blink: 1'b0};
                    3'd2:    e = '{colour: COL_YEL, blink: 1'b0};
                    3'd3:    e = '{colour: COL_YEL, blink: 1'b1};
                    3'd4:    e = '{colour: COL_GRN, blink: 1'b0};
                    default: e = '{colour: COL_OFF, blink: 1'b0};
                endcase
            end
            LED_STEER: begin
                case (steer)
                    2'd1:    e = '{colour: COL_YEL, blink: 1'b0};
                    2'd2:    e = '{colour: COL_GRN, blink: 1'b1};
                    2'd3:    e = '{colour: COL_GRN, blink: 1'b0};
                    default: e = '{colour: COL_OFF, blink: 1'b0};
                endcase
            end
            default: begin
                case (inr)
                    2'd1:    e = '{colour: COL_RED, blink: 1'b1};
                    2'd2:    e = '{colour: COL_YEL, blink: 1'b0};
                    2'd3:    e = '{colour: COL_GRN, blink: 1'b0};
                    default: e = '{colour: COL_OFF, blink: 1'b0};
                endcase
            end
        endcase
        return e;
    endfunction

endpackage

@@ hdl/status_led_panel_controller.sv @@
// Status LED panel controller: after an input transfer the shared multiply/divide-by-100 unit
// runs five times, each run an S_MUL state then an S_DIV state; then the results are offered,
// one result per cycle while the output is not stalled (four results per item). Stall is high
// from the accept until the last result is taken, so a new item is not taken before then.
// Synchronous active-low reset: brightness 100, interval 500, codes, phases and count cleared.
// Depends on slpc_pkg and status_led_panel_controller_defines.svh.
`include "status_led_panel_controller_defines.svh"

module status_led_panel_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration port
    input  logic                               i_cfg_we,
    input  logic [slpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [slpc_pkg::CFG_W-1:0]         i_cfg_data,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_opcode,
    input  logic                               i_ethernet_up,
    input  logic                               i_host_receiving,
    input  logic                               i_gnss_present,
    input  logic [7:0]                         i_fix_quality,
    input  logic                               i_imu_present,
    input  logic                               i_imu_initialized,
    input  logic                               i_imu_data_valid,
    input  logic                               i_ins_present,
    input  logic [7:0]                         i_ins_alignment,
    input  logic [1:0]                         i_steer_state,
    // output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_led_index,
    output logic [slpc_pkg::DUTY_BITS-1:0]     o_red_duty,
    output logic [slpc_pkg::DUTY_BITS-1:0]     o_green_duty,
    output logic [slpc_pkg::DUTY_BITS-1:0]     o_blue_duty,
    output logic                               o_last_led
);

    // scaled values kept per item
    localparam logic [2:0] VAL_CFULL = 3'd0;
    localparam logic [2:0] VAL_CHALF = 3'd1;
    localparam logic [2:0] VAL_RED   = 3'd2;
    localparam logic [2:0] VAL_YR    = 3'd3;
    localparam logic [2:0] VAL_YG    = 3'd4;
    localparam int         NUM_VALS  = 5;

    // control state
    slpc_pkg::t_state                      r_state, n_state;
    logic [2:0]                            r_op, n_op;
    logic [1:0]                            r_led, n_led;

    // block state
    logic [slpc_pkg::BRIGHT_W-1:0]         r_bright;
    logic [slpc_pkg::TICK_W-1:0]           r_interval;
    logic [1:0]                            r_pwr_code;
    logic [2:0]                            r_gnss_code;
    logic [1:0]                            r_steer_code;
    logic [1:0]                            r_inr_code;
    logic [3:0]                            r_phase;
    logic                                  r_gphase;
    logic [slpc_pkg::TICK_W-1:0]           r_tick;

    // datapath
    logic [slpc_pkg::MUL_W-1:0]            r_prod;
    logic [slpc_pkg::DUTY_BITS-1:0]        r_val [NUM_VALS];

    logic                                  w_in_xfer;
    logic                                  w_out_xfer;

    // sample classification
    logic [1:0]                            w_pwr_new;
    logic [2:0]                            w_gnss_new;
    logic [1:0]                            w_inr_new;

    // tick path
    logic [slpc_pkg::TICK_W-1:0]           w_tick_inc;
    logic                                  w_toggle;
    logic [3:0]                            w_blink;

    // config clamp
    logic [slpc_pkg::BRIGHT_W-1:0]         w_cfg_bright;

    // shared unit signals
    logic [slpc_pkg::DUTY_BITS-1:0]        w_op_x;
    logic [slpc_pkg::BRIGHT_W-1:0]         w_op_y;
    logic [slpc_pkg::RCP_W-1:0]            w_rcp;
    logic [slpc_pkg::QUO_W-1:0]            w_q0;
    logic [slpc_pkg::MUL_W-1:0]            w_q0x;
    logic [slpc_pkg::MUL_W-1:0]            w_rem;
    logic [slpc_pkg::QUO_W-1:0]            w_quo;

    // result select
    slpc_pkg::t_led_entry                  w_ent;
    logic                                  w_on;

    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_xfer = o_valid && !i_stall;
    assign o_stall    = (r_state != slpc_pkg::S_IDLE);
    assign o_valid    = (r_state == slpc_pkg::S_EMIT);

    // classify the status sample
    always_comb begin
        w_pwr_new = !i_ethernet_up ? 2'd0 : (!i_host_receiving ? 2'd1 : 2'd2);
        if (!i_gnss_present)            w_gnss_new = 3'd0;
        else if (i_fix_quality == 8'd0) w_gnss_new = 3'd1;
        else if (i_fix_quality == 8'd5) w_gnss_new = 3'd3;
        else if (i_fix_quality == 8'd4) w_gnss_new = 3'd4;
        else                            w_gnss_new = 3'd2;
        if (i_imu_present) begin
            w_inr_new = !i_imu_initialized ? 2'd1 : (!i_imu_data_valid ? 2'd2 : 2'd3);
        end else if (i_ins_present) begin
            w_inr_new = (i_ins_alignment == 8'd0) ? 2'd1 :
                        ((i_ins_alignment == 8'd3) ? 2'd3 : 2'd2);
        end else begin
            w_inr_new = 2'd0;
        end
    end

    // blink timer
    assign w_tick_inc = r_tick + slpc_pkg::TICK_W'(1);
    assign w_toggle   = (w_tick_inc >= r_interval);

    // blink mode of every led under the current codes
    always_comb begin
        slpc_pkg::t_led_entry ent;
        w_blink = '0;
        for (int k = 0; k < 4; k++) begin
            ent        = slpc_pkg::f_led_entry(2'(k), r_pwr_code, r_gnss_code,
                                               r_steer_code, r_inr_code);
            w_blink[k] = ent.blink;
        end
    end

    // brightness clamp on write
    always_comb begin
        w_cfg_bright = i_cfg_data[slpc_pkg::BRIGHT_W-1:0];
        if (w_cfg_bright < slpc_pkg::BRIGHT_MIN) w_cfg_bright = slpc_pkg::BRIGHT_MIN;
        if (w_cfg_bright > slpc_pkg::BRIGHT_MAX) w_cfg_bright = slpc_pkg::BRIGHT_MAX;
    end

    // configuration and status state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright     <= slpc_pkg::BRIGHT_RST;
            r_interval   <= slpc_pkg::BLINK_RST;
            r_pwr_code   <= '0;
            r_gnss_code  <= '0;
            r_steer_code <= '0;
            r_inr_code   <= '0;
            r_phase      <= '0;
            r_gphase     <= 1'b0;
            r_tick       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    slpc_pkg::REG_BRIGHTNESS: r_bright   <= w_cfg_bright;
                    slpc_pkg::REG_BLINK:      r_interval <= i_cfg_data[slpc_pkg::TICK_W-1:0];
                    default: ;
                endcase
            end
            if (w_in_xfer) begin
                if (i_opcode == slpc_pkg::OP_SAMPLE) begin
                    // a code change restarts that led dark
                    r_pwr_code   <= w_pwr_new;
                    r_gnss_code  <= w_gnss_new;
                    r_steer_code <= i_steer_state;
                    r_inr_code   <= w_inr_new;
                    if (r_pwr_code != w_pwr_new)      r_phase[0] <= 1'b0;
                    if (r_gnss_code != w_gnss_new)    r_phase[1] <= 1'b0;
                    if (r_steer_code != i_steer_state) r_phase[2] <= 1'b0;
                    if (r_inr_code != w_inr_new)      r_phase[3] <= 1'b0;
                end else if (w_toggle) begin
                    // phase toggle, copied by every blinking led
                    r_tick   <= '0;
                    r_gphase <= !r_gphase;
                    for (int k = 0; k < 4; k++) begin
                        if (w_blink[k]) begin
                            r_phase[k] <= !r_gphase;
                        end
                    end
                end else begin
                    r_tick <= w_tick_inc;
                end
            end
        end
    end

    // operand select for the shared unit
    always_comb begin
        case (r_op)
            VAL_CFULL: begin w_op_x = slpc_pkg::DUTY_FULL;  w_op_y = r_bright; end
            VAL_CHALF: begin w_op_x = slpc_pkg::DUTY_HALF;  w_op_y = r_bright; end
            VAL_RED:   begin w_op_x = r_val[VAL_CFULL];     w_op_y = slpc_pkg::PCT_RED; end
            VAL_YR:    begin w_op_x = r_val[VAL_CFULL];     w_op_y = slpc_pkg::PCT_YEL; end
            VAL_YG:    begin w_op_x = r_val[VAL_CHALF];     w_op_y = slpc_pkg::PCT_YEL; end
            default:   begin w_op_x = '0;                   w_op_y = '0; end
        endcase
    end

    // divide by 100: reciprocal multiply, then one correction step
    always_comb begin
        w_rcp = slpc_pkg::RCP_W'(r_prod) * slpc_pkg::RCP_W'(slpc_pkg::RCP_MUL);
        w_q0  = w_rcp[slpc_pkg::RCP_SHIFT +: slpc_pkg::QUO_W];
        w_q0x = slpc_pkg::MUL_W'(w_q0) * slpc_pkg::MUL_W'(slpc_pkg::PCT_SCALE);
        w_rem = r_prod - w_q0x;
        w_quo = (w_rem >= slpc_pkg::MUL_W'(slpc_pkg::PCT_SCALE)) ?
                w_q0 + slpc_pkg::QUO_W'(1) : w_q0;
    end

    // shared unit registers
    always_ff @(posedge i_clk) begin
        if (r_state == slpc_pkg::S_MUL) begin
            r_prod <= slpc_pkg::MUL_W'(w_op_x) * slpc_pkg::MUL_W'(w_op_y);
        end
        if (r_state == slpc_pkg::S_DIV) begin
            r_val[r_op] <= w_quo[slpc_pkg::DUTY_BITS-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_led   = r_led;
        case (r_state)
            slpc_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = slpc_pkg::S_MUL;
                    n_op    = VAL_CFULL;
                end
            end
            slpc_pkg::S_MUL: begin
                n_state = slpc_pkg::S_DIV;
            end
            slpc_pkg::S_DIV: begin
                if (r_op == VAL_YG) begin
                    n_state = slpc_pkg::S_EMIT;
                    n_led   = slpc_pkg::LED_POWER;
                end else begin
                    n_state = slpc_pkg::S_MUL;
                    n_op    = r_op + 3'd1;
                end
            end
            slpc_pkg::S_EMIT: begin
                if (w_out_xfer) begin
                    if (r_led == slpc_pkg::LED_INERTIAL) n_state = slpc_pkg::S_IDLE;
                    n_led = r_led + 2'd1;
                end
            end
            default: begin
                n_state = slpc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slpc_pkg::S_IDLE;
            r_op    <= '0;
            r_led   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_led   <= n_led;
        end
    end

    // result for the current led
    always_comb begin
        w_ent = slpc_pkg::f_led_entry(r_led, r_pwr_code, r_gnss_code,
                                      r_steer_code, r_inr_code);
        w_on  = !w_ent.blink || r_phase[r_led];
        o_red_duty   = '0;
        o_green_duty = '0;
        if (w_on) begin
            case (w_ent.colour)
                slpc_pkg::COL_RED: o_red_duty = r_val[VAL_RED];
                slpc_pkg::COL_YEL: begin
                    o_red_duty   = r_val[VAL_YR];
                    o_green_duty = r_val[VAL_YG];
                end
                slpc_pkg::COL_GRN: o_green_duty = r_val[VAL_CFULL];
                default: ;
            endcase
        end
    end

    assign o_blue_duty = '0;
    assign o_led_index = r_led;
    assign o_last_led  = (r_led == slpc_pkg::LED_INERTIAL);

    // checks
    `SLPC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_xfer, o_stall && !o_valid)
    `SLPC_ASSERT_HOLDS(a_bright_range, i_clk, i_rst_n, 1'b1,
        (r_bright >= slpc_pkg::BRIGHT_MIN) && (r_bright <= slpc_pkg::BRIGHT_MAX))
    `SLPC_ASSERT_NEXT(a_led_order, i_clk, i_rst_n, w_out_xfer && !o_last_led,
        o_valid && (o_led_index == 2'($past(o_led_index) + 2'd1)))
    `SLPC_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, w_out_xfer && o_last_led, !o_valid && !o_stall)

endmodule
